FILE: hdl/leg_pkg.sv
// shared constants, types and helper functions of the legendre evaluator
package leg_pkg;

  // default highest degree that the recurrence runs to
  localparam int unsigned MAX_DEGREE_DEF = 16;

  // word widths: running values, wide accumulators, multiplier operands
  localparam int RUN_W = 52;
  localparam int ACC_W = 64;
  localparam int MUL_W = 32;
  localparam int FRAC  = 30;

  // field widths
  localparam int POINT_W  = 32;
  localparam int VALUE_W  = 32;
  localparam int D1_W     = 39;
  localparam int D2_W     = 45;
  localparam int DEGREE_W = 5;

  // fixed point constants (q30)
  localparam logic signed [ACC_W-1:0] Q_ONE       = 64'sd1073741824;
  localparam logic signed [ACC_W-1:0] RUN_LIMIT   = 64'sd1125899906842624;
  localparam logic signed [ACC_W-1:0] VALUE_LIMIT = 64'sd1073741824;
  localparam logic signed [ACC_W-1:0] D1_LIMIT    = 64'sd146028888064;
  localparam logic signed [ACC_W-1:0] D2_LIMIT    = 64'sd9856732282880;
  localparam logic [ACC_W-1:0]        ROUND_HALF  = 64'd536870912;
  localparam logic [DEGREE_W-1:0]     DEGREE_RST  = 5'd2;

  // sequencer states
  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_XLO   = 11'b00000000010,
    ST_XHI   = 11'b00000000100,
    ST_XSUM  = 11'b00000001000,
    ST_ADDE  = 11'b00000010000,
    ST_SCALE = 11'b00000100000,
    ST_RLO   = 11'b00001000000,
    ST_RHI   = 11'b00010000000,
    ST_RSUM  = 11'b00100000000,
    ST_ADV   = 11'b01000000000,
    ST_DONE  = 11'b10000000000
  } state_t;

  // which running value (0 value, 1 first, 2 second derivative)
  localparam logic [1:0] SEL_VAL = 2'd0;
  localparam logic [1:0] SEL_D1  = 2'd1;
  localparam logic [1:0] SEL_D2  = 2'd2;

  // sequencer to datapath control
  typedef struct packed {
    state_t     state;
    logic [1:0] k;
  } seq_ctrl_t;

  // q30 reciprocal round(2^30 / i) for the loop index
  function automatic logic [29:0] recip_q30(input logic [5:0] i);
    logic [29:0] r;
    begin
      unique case (i)
        6'd2:    r = 30'd536870912;
        6'd3:    r = 30'd357913941;
        6'd4:    r = 30'd268435456;
        6'd5:    r = 30'd214748365;
        6'd6:    r = 30'd178956971;
        6'd7:    r = 30'd153391689;
        6'd8:    r = 30'd134217728;
        6'd9:    r = 30'd119304647;
        6'd10:   r = 30'd107374182;
        6'd11:   r = 30'd97612893;
        6'd12:   r = 30'd89478485;
        6'd13:   r = 30'd82595525;
        6'd14:   r = 30'd76695845;
        6'd15:   r = 30'd71582788;
        6'd16:   r = 30'd67108864;
        6'd17:   r = 30'd63161284;
        6'd18:   r = 30'd59652324;
        6'd19:   r = 30'd56512728;
        6'd20:   r = 30'd53687091;
        6'd21:   r = 30'd51130563;
        6'd22:   r = 30'd48806447;
        6'd23:   r = 30'd46684427;
        6'd24:   r = 30'd44739243;
        6'd25:   r = 30'd42949673;
        6'd26:   r = 30'd41297762;
        6'd27:   r = 30'd39768216;
        6'd28:   r = 30'd38347922;
        6'd29:   r = 30'd37025580;
        6'd30:   r = 30'd35791394;
        6'd31:   r = 30'd34636833;
        6'd32:   r = 30'd33554432;
        default: r = 30'd0;
      endcase
      return r;
    end
  endfunction

  // symmetric saturation
  function automatic logic signed [ACC_W-1:0] clamp_sym(
    input logic signed [ACC_W-1:0] v,
    input logic signed [ACC_W-1:0] lim
  );
    logic signed [ACC_W-1:0] o;
    begin
      if (v > lim) o = lim;
      else if (v < -lim) o = -lim;
      else o = v;
      return o;
    end
  endfunction

  // magnitude of a signed word
  function automatic logic [ACC_W-1:0] abs_w(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] o;
    begin
      o = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
      return o;
    end
  endfunction

endpackage

FILE: hdl/leg_mul.sv
// shared unsigned 32x32 multiplier with registered product
module leg_mul (
  input  logic                             clk,
  input  logic [leg_pkg::MUL_W-1:0]        a,
  input  logic [leg_pkg::MUL_W-1:0]        b,
  output logic [2*leg_pkg::MUL_W-1:0]      prod
);

  // one partial product per cycle
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

FILE: hdl/leg_seq.sv
// sequencer: walks the recurrence steps and the three running values
module leg_seq #(
  parameter int unsigned MAX_DEGREE = leg_pkg::MAX_DEGREE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                go,
  input  logic [$clog2(MAX_DEGREE+1)-1:0]     n,
  output leg_pkg::seq_ctrl_t                  ctrl,
  output logic [$clog2(MAX_DEGREE+1)-1:0]     i,
  output logic                                busy
);

  localparam int IW = $clog2(MAX_DEGREE + 1);

  leg_pkg::state_t state, state_next;
  logic [1:0]      k, k_next;
  logic [IW-1:0]   i_next;
  logic [IW-1:0]   n_q;

  // next state
  always_comb begin
    state_next = state;
    k_next     = k;
    i_next     = i;
    unique case (state)
      leg_pkg::ST_IDLE: begin
        if (go) begin
          k_next = leg_pkg::SEL_VAL;
          i_next = IW'(2);
          state_next = (n < IW'(2)) ? leg_pkg::ST_DONE : leg_pkg::ST_XLO;
        end
      end
      leg_pkg::ST_XLO:   state_next = leg_pkg::ST_XHI;
      leg_pkg::ST_XHI:   state_next = leg_pkg::ST_XSUM;
      leg_pkg::ST_XSUM:  state_next = leg_pkg::ST_ADDE;
      leg_pkg::ST_ADDE:  state_next = leg_pkg::ST_SCALE;
      leg_pkg::ST_SCALE: state_next = leg_pkg::ST_RLO;
      leg_pkg::ST_RLO:   state_next = leg_pkg::ST_RHI;
      leg_pkg::ST_RHI:   state_next = leg_pkg::ST_RSUM;
      leg_pkg::ST_RSUM: begin
        if (k == leg_pkg::SEL_D2) begin
          k_next = leg_pkg::SEL_VAL;
          state_next = leg_pkg::ST_ADV;
        end else begin
          k_next = k + 2'd1;
          state_next = leg_pkg::ST_XLO;
        end
      end
      leg_pkg::ST_ADV: begin
        if (i == n_q) begin
          state_next = leg_pkg::ST_DONE;
        end else begin
          i_next = i + IW'(1);
          state_next = leg_pkg::ST_XLO;
        end
      end
      leg_pkg::ST_DONE:  state_next = leg_pkg::ST_IDLE;
      default:           state_next = leg_pkg::ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= leg_pkg::ST_IDLE;
      k     <= leg_pkg::SEL_VAL;
      i     <= IW'(2);
    end else begin
      state <= state_next;
      k     <= k_next;
      i     <= i_next;
    end
  end

  // degree of the item in flight
  always_ff @(posedge clk) begin
    if (go) begin
      n_q <= n;
    end
  end

  assign ctrl.state = state;
  assign ctrl.k     = k;
  assign busy       = (state != leg_pkg::ST_IDLE);

endmodule

FILE: hdl/legendre_poly_and_derivatives.sv
// top level: legendre value and derivatives by the three-term recurrence
//
//   channel   signals                                   accepted when
//   -------   ---------------------------------------   -----------------------------
//   item in   start, busy, point                         start high and busy low
//   config    degree_valid, degree_ready, degree        degree_valid and degree_ready
//   result    done, value, first_derivative,            done high (one cycle)
//             second_derivative
//
// in each recurrence step each of the three running values goes through two
// q30 products on the single shared 32x32 multiplier, each split into low and
// high partial products. for degree n >= 2 the steps run for i from 2 to n;
// for degree 0 or 1 the sequencer goes straight to the result strobe.
// busy is high for the whole item. synchronous reset sets degree to 2 and
// returns to idle. the result is shown for one cycle; the receiver cannot stall.
module legendre_poly_and_derivatives #(
  parameter int unsigned MAX_DEGREE = leg_pkg::MAX_DEGREE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [leg_pkg::POINT_W-1:0]   point,
  input  logic                                 degree_valid,
  output logic                                 degree_ready,
  input  logic [leg_pkg::DEGREE_W-1:0]         degree,
  output logic                                 done,
  output logic signed [leg_pkg::VALUE_W-1:0]   value,
  output logic signed [leg_pkg::D1_W-1:0]      first_derivative,
  output logic signed [leg_pkg::D2_W-1:0]      second_derivative
);

  localparam int IW    = $clog2(MAX_DEGREE + 1);
  localparam int CW    = IW + 1;
  localparam int RUN_W = leg_pkg::RUN_W;
  localparam int ACC_W = leg_pkg::ACC_W;
  localparam int MUL_W = leg_pkg::MUL_W;
  localparam int FRAC  = leg_pkg::FRAC;

  logic [leg_pkg::DEGREE_W-1:0] deg;
  logic                         go;
  logic [IW-1:0]                n_eff;
  leg_pkg::seq_ctrl_t           ctrl;
  logic [IW-1:0]                i;

  logic [FRAC:0]                ux;
  logic                         xs;
  logic signed [RUN_W-1:0]      v  [3];
  logic signed [RUN_W-1:0]      p  [3];
  logic signed [RUN_W-1:0]      nv [3];
  logic [ACC_W-1:0]             acc;
  logic [ACC_W-1:0]             bmag;
  logic                         pneg;
  logic signed [ACC_W-1:0]      xv;
  logic signed [ACC_W-1:0]      s1;
  logic signed [ACC_W-1:0]      sum;

  logic [MUL_W-1:0]             mul_a, mul_b;
  logic [2*MUL_W-1:0]           prod;

  logic signed [ACC_W-1:0]      x_clamp;
  logic signed [ACC_W-1:0]      v_sel, p_sel, mul_src, e_sel;
  logic [ACC_W-1:0]             mul_mag;
  logic [ACC_W-1:0]             t_mag;
  logic signed [ACC_W-1:0]      t_sgn;
  logic [29:0]                  r;
  logic [CW-1:0]                c2;
  logic [IW-1:0]                c4;
  logic                         r_phase;
  logic                         lo_phase;

  // configuration register, always ready
  assign degree_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      deg <= leg_pkg::DEGREE_RST;
    end else if (degree_valid && degree_ready) begin
      deg <= degree;
    end
  end

  // degree clipped to the supported maximum
  assign n_eff = (32'(deg) > MAX_DEGREE) ? IW'(MAX_DEGREE) : IW'(deg);
  assign go    = start && !busy;

  leg_seq #(
    .MAX_DEGREE(MAX_DEGREE)
  ) u_seq (
    .clk (clk),
    .rst (rst),
    .go  (go),
    .n   (n_eff),
    .ctrl(ctrl),
    .i   (i),
    .busy(busy)
  );

  // per-step coefficients
  assign r  = leg_pkg::recip_q30(6'(i));
  assign c2 = {i, 1'b0} - CW'(1);
  assign c4 = i - IW'(1);

  // operand selection for the shared multiplier
  always_comb begin
    x_clamp  = leg_pkg::clamp_sym(ACC_W'(point), leg_pkg::Q_ONE);
    v_sel    = ACC_W'(v[ctrl.k]);
    p_sel    = ACC_W'(p[ctrl.k]);
    r_phase  = (ctrl.state == leg_pkg::ST_RLO) || (ctrl.state == leg_pkg::ST_RHI);
    lo_phase = (ctrl.state == leg_pkg::ST_XLO) || (ctrl.state == leg_pkg::ST_RLO);
    mul_src  = (ctrl.state == leg_pkg::ST_RLO) ? sum : v_sel;
    mul_mag  = leg_pkg::abs_w(mul_src);
    mul_a    = r_phase ? MUL_W'(r) : MUL_W'(ux);
    mul_b    = lo_phase ? MUL_W'(mul_mag[FRAC-1:0]) : bmag[FRAC+MUL_W-1:FRAC];
    t_mag    = acc + prod;
    t_sgn    = pneg ? -$signed(t_mag) : $signed(t_mag);
  end

  // extra term folded in before the scale by 2i-1
  always_comb begin
    unique case (ctrl.k)
      leg_pkg::SEL_D1: e_sel = ACC_W'(v[0]);
      leg_pkg::SEL_D2: e_sel = ACC_W'(v[1]) <<< 1;
      default:         e_sel = '0;
    endcase
  end

  leg_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .prod(prod)
  );

  // datapath registers
  always_ff @(posedge clk) begin
    if (go) begin
      ux <= (FRAC+1)'(leg_pkg::abs_w(x_clamp));
      xs <= x_clamp[ACC_W-1];
      if (n_eff == '0) begin
        v[0] <= RUN_W'(leg_pkg::Q_ONE);
        v[1] <= '0;
      end else begin
        v[0] <= RUN_W'(x_clamp);
        v[1] <= RUN_W'(leg_pkg::Q_ONE);
      end
      v[2] <= '0;
      p[0] <= RUN_W'(leg_pkg::Q_ONE);
      p[1] <= '0;
      p[2] <= '0;
    end else begin
      unique case (ctrl.state)
        leg_pkg::ST_XLO: begin
          bmag <= mul_mag;
          pneg <= xs ^ v_sel[ACC_W-1];
        end
        leg_pkg::ST_RLO: begin
          bmag <= mul_mag;
          pneg <= sum[ACC_W-1];
        end
        leg_pkg::ST_XHI, leg_pkg::ST_RHI: begin
          acc <= (prod + leg_pkg::ROUND_HALF) >> FRAC;
        end
        leg_pkg::ST_XSUM: begin
          xv <= t_sgn;
        end
        leg_pkg::ST_ADDE: begin
          s1 <= xv + e_sel;
        end
        leg_pkg::ST_SCALE: begin
          sum <= s1 * $signed({1'b0, c2}) - p_sel * $signed({1'b0, c4});
        end
        leg_pkg::ST_RSUM: begin
          nv[ctrl.k] <= RUN_W'(leg_pkg::clamp_sym(t_sgn, leg_pkg::RUN_LIMIT));
        end
        leg_pkg::ST_ADV: begin
          p <= v;
          v <= nv;
        end
        default: begin
        end
      endcase
    end
  end

  // result registers with field saturation
  always_ff @(posedge clk) begin
    if (ctrl.state == leg_pkg::ST_DONE) begin
      value <= leg_pkg::VALUE_W'(
        leg_pkg::clamp_sym(ACC_W'(v[0]), leg_pkg::VALUE_LIMIT));
      first_derivative <= leg_pkg::D1_W'(
        leg_pkg::clamp_sym(ACC_W'(v[1]), leg_pkg::D1_LIMIT));
      second_derivative <= leg_pkg::D2_W'(
        leg_pkg::clamp_sym(ACC_W'(v[2]), leg_pkg::D2_LIMIT));
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (ctrl.state == leg_pkg::ST_DONE);
    end
  end

endmodule

FILE: hdl/leg_chk.sv
// port-level checks of the legendre evaluator, bound to the top level
module leg_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic                               done,
  input logic signed [leg_pkg::VALUE_W-1:0] value,
  input logic signed [leg_pkg::D1_W-1:0]    first_derivative
);

  // reset leaves the block idle
  a_rst_idle: assert property (@(posedge clk) rst |=> !busy)
    else $error("busy after reset");

  // an accepted item keeps the block busy
  a_go_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  // a result only ends a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result without an item in flight");

  // value stays within [-1, 1]
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (value <= 32'sd1073741824 && value >= -32'sd1073741824))
    else $error("value out of range");

  // first derivative stays within its saturation bound
  a_d1_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (first_derivative <= 39'sd146028888064 &&
              first_derivative >= -39'sd146028888064))
    else $error("first derivative out of range");

endmodule

bind legendre_poly_and_derivatives leg_chk u_leg_chk (.*);
